// ===== hw/rtl/isiq_pkg.sv =====
`default_nettype none
package isiq_pkg;

    localparam int MAX_RANGES_DEF   = 64;
    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int CALL_W           = 32;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } isiq_state_t;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } isiq_cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;
        logic cmp;
        logic upd;
    } dp_ctl_t;

    // Status from the datapath.
    typedef struct packed {
        logic contained;
        logic dropped_full;
        logic full;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/isiq_if.sv =====
`default_nettype none
interface isiq_req_if;
    import isiq_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CALL_W-1:0] call_number;
    modport source (output valid, output cmd, output call_number, input ready);
    modport sink   (input valid, input cmd, input call_number, output ready);
endinterface

interface isiq_rsp_if;
    logic valid;
    logic ready;
    logic contained;
    logic dropped_full;
    modport source (output valid, output contained, output dropped_full, input ready);
    modport sink   (input valid, input contained, input dropped_full, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/isiq_ctrl.sv =====
`default_nettype none
module isiq_ctrl
    import isiq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dp_ctl_t   ctl
);

    isiq_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cap    = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.cmp    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // The result register must be free before the table is touched.
                if (!out_valid_reg || out_ready)
                begin
                    ctl.upd        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/isiq_dp.sv =====
`default_nettype none
module isiq_dp
    import isiq_pkg::*;
#(
    parameter int MaxRanges   = MAX_RANGES_DEF,
    parameter int NumberWidth = NUMBER_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_ctl_t           ctl,
    input  wire logic              cmd_in,
    input  wire logic [CALL_W-1:0] num_in,
    output dp_stat_t               stat
);

    localparam int XW = NumberWidth + 1;

    logic                   cmd_reg;
    logic [NumberWidth-1:0] x_reg;
    logic [NumberWidth-1:0] start_reg [MaxRanges];
    logic [NumberWidth-1:0] end_reg   [MaxRanges];
    logic [NumberWidth-1:0] start_next [MaxRanges];
    logic [NumberWidth-1:0] end_next   [MaxRanges];
    logic [MaxRanges-1:0]   valid_reg, valid_next;
    logic [MaxRanges-1:0]   lt_reg, up_reg, dn_reg, cov_reg;
    logic [MaxRanges-1:0]   lt_c, up_c, dn_c, cov_c, mrg, ins;
    logic                   contained_reg, dropped_reg;
    logic [XW-1:0]          x_inc;
    logic                   covered, any_up, any_dn, mrg_any, full, do_add, drop;

    assign x_inc = {1'b0, x_reg} + XW'(1);

    // Per-range compares; each range only looks at its own bounds.
    always_comb
    begin
        for (int i = 0; i < MaxRanges; i++)
        begin
            lt_c[i]  = valid_reg[i] && (end_reg[i] < x_reg);
            cov_c[i] = valid_reg[i] && (start_reg[i] <= x_reg) && (x_reg <= end_reg[i]);
            up_c[i]  = valid_reg[i] && (({1'b0, end_reg[i]} + XW'(1)) == {1'b0, x_reg});
            dn_c[i]  = valid_reg[i] && ({1'b0, start_reg[i]} == x_inc);
        end
    end

    assign covered = |cov_reg;
    assign any_up  = |up_reg;
    assign any_dn  = |dn_reg;
    assign full    = valid_reg[MaxRanges-1];
    assign do_add  = (cmd_reg == CMD_ADD) && !covered;
    assign drop    = do_add && !any_up && !any_dn && full;

    always_comb
    begin
        for (int i = 0; i < MaxRanges; i++)
        begin
            mrg[i] = (i < MaxRanges - 1) ? (up_reg[i] && dn_reg[(i + 1) % MaxRanges]) : 1'b0;
            ins[i] = !lt_reg[i] && ((i == 0) ? 1'b1 : lt_reg[(i + MaxRanges - 1) % MaxRanges]);
        end
    end

    assign mrg_any = |mrg;

    // One update step over the table: extend a neighbouring range in place, shift left on a merge, right on an insert.
    always_comb
    begin
        for (int i = 0; i < MaxRanges; i++)
        begin
            start_next[i] = start_reg[i];
            end_next[i]   = end_reg[i];
            valid_next[i] = valid_reg[i];
            if (do_add && any_up)
            begin
                if (up_reg[i])
                begin
                    end_next[i] = mrg_any ? end_reg[(i + 1) % MaxRanges] : x_reg;
                end
                else if (mrg_any && !lt_reg[i])
                begin
                    if (i < MaxRanges - 1)
                    begin
                        start_next[i] = start_reg[(i + 1) % MaxRanges];
                        end_next[i]   = end_reg[(i + 1) % MaxRanges];
                        valid_next[i] = valid_reg[(i + 1) % MaxRanges];
                    end
                    else
                    begin
                        valid_next[i] = 1'b0;
                    end
                end
            end
            else if (do_add && any_dn)
            begin
                if (dn_reg[i])
                begin
                    start_next[i] = x_reg;
                end
            end
            else if (do_add && !full)
            begin
                if (ins[i])
                begin
                    start_next[i] = x_reg;
                    end_next[i]   = x_reg;
                    valid_next[i] = 1'b1;
                end
                else if (i > 0 && !lt_reg[(i + MaxRanges - 1) % MaxRanges])
                begin
                    start_next[i] = start_reg[(i + MaxRanges - 1) % MaxRanges];
                    end_next[i]   = end_reg[(i + MaxRanges - 1) % MaxRanges];
                    valid_next[i] = valid_reg[(i + MaxRanges - 1) % MaxRanges];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.upd)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            cmd_reg <= cmd_in;
            x_reg   <= NumberWidth'(num_in);
        end
        if (ctl.cmp)
        begin
            lt_reg  <= lt_c;
            up_reg  <= up_c;
            dn_reg  <= dn_c;
            cov_reg <= cov_c;
        end
        if (ctl.upd)
        begin
            start_reg     <= start_next;
            end_reg       <= end_next;
            contained_reg <= covered;
            dropped_reg   <= drop;
        end
    end

    assign stat.contained    = contained_reg;
    assign stat.dropped_full = dropped_reg;
    assign stat.full         = full;

endmodule
`default_nettype wire

// ===== hw/rtl/interval_set_insert_and_query.sv =====
// Channel  Role     Payload
// req      sink     cmd, call_number
// rsp      source   contained, dropped_full
//
// Each transaction passes three steps: capture, a parallel compare of the
// number against every stored range, then one update step of the table.
// One item is in work at a time; the result waits in an output register.
// A stalled rsp holds the controller in its update state until taken.
// Reset empties the table at once through its valid bits.
`default_nettype none
module interval_set_insert_and_query
    import isiq_pkg::*;
#(
    parameter int MAX_RANGES   = MAX_RANGES_DEF,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    isiq_req_if.sink    req,
    isiq_rsp_if.source  rsp
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    isiq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    isiq_dp #(
        .MaxRanges   (MAX_RANGES),
        .NumberWidth (NUMBER_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cmd_in (req.cmd),
        .num_in (req.call_number),
        .stat   (stat)
    );

    assign rsp.contained    = stat.contained;
    assign rsp.dropped_full = stat.dropped_full;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("transaction accepted while another is in work");

    a_drop_not_covered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.contained && rsp.dropped_full))
        else $error("covered number reported as dropped");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.dropped_full) |-> stat.full)
        else $error("drop reported with free table space");

endmodule
`default_nettype wire

// ===== tb/sv/isiq_tb_if.sv =====
`timescale 1ns / 1ps
// The block's own interfaces (isiq_req_if, isiq_rsp_if) are used directly;
// this file holds the shared transaction record for the test.
package isiq_tb_pkg;
    import isiq_pkg::*;

    typedef struct packed {
        logic contained;
        logic dropped_full;
    } isiq_answer_t;
endpackage

// ===== tb/sv/interval_set_insert_and_query_test.sv =====
`timescale 1ns / 1ps
module interval_set_insert_and_query_test;
    import isiq_pkg::*;
    import isiq_tb_pkg::*;

    localparam int TABLE_DEPTH = MAX_RANGES_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    isiq_req_if req ();
    isiq_rsp_if rsp ();

    interval_set_insert_and_query DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow copy of the range table.
    logic [31:0] lo_tab [TABLE_DEPTH];
    logic [31:0] hi_tab [TABLE_DEPTH];
    int unsigned used_ranges;

    isiq_answer_t pending_answers [$];
    int unsigned mismatch_count;
    int unsigned answers_seen;
    int unsigned drops_seen;
    longint cycle_count = 0;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic isiq_answer_t apply_number(input isiq_cmd_t op, input logic [31:0] x);
        isiq_answer_t ans;
        int unsigned slot;
        logic hit;
        slot = 0;
        while (slot < used_ranges && hi_tab[slot] < x)
            slot++;
        hit = (slot < used_ranges) && (lo_tab[slot] <= x);
        ans.contained = hit;
        ans.dropped_full = 1'b0;
        if (op == CMD_ADD && !hit)
        begin
            if (slot > 0 && hi_tab[slot-1] + 32'd1 == x)
            begin
                hi_tab[slot-1] = x;
                if (slot < used_ranges && x != 32'hFFFF_FFFF && lo_tab[slot] == x + 32'd1)
                begin
                    hi_tab[slot-1] = hi_tab[slot];
                    for (int i = slot; i + 1 < used_ranges; i++)
                    begin
                        lo_tab[i] = lo_tab[i+1];
                        hi_tab[i] = hi_tab[i+1];
                    end
                    used_ranges--;
                end
            end
            else if (slot < used_ranges && x != 32'hFFFF_FFFF && lo_tab[slot] == x + 32'd1)
                lo_tab[slot] = x;
            else if (used_ranges >= TABLE_DEPTH)
                ans.dropped_full = 1'b1;
            else
            begin
                for (int i = used_ranges; i > slot; i--)
                begin
                    lo_tab[i] = lo_tab[i-1];
                    hi_tab[i] = hi_tab[i-1];
                end
                lo_tab[slot] = x;
                hi_tab[slot] = x;
                used_ranges++;
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Sends one transaction; the expectation is queued at acceptance.
    // Valid stays high after acceptance so that items can follow without a gap.
    task automatic send_number(input isiq_cmd_t op, input logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= op;
        req.call_number <= x;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_answers.push_back(apply_number(op, x));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            isiq_answer_t want;
            answers_seen++;
            if (pending_answers.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.contained !== want.contained)
                    report_mismatch($sformatf("contained %b, expected %b",
                                              rsp.contained, want.contained));
                if (rsp.dropped_full !== want.dropped_full)
                    report_mismatch($sformatf("dropped_full %b, expected %b",
                                              rsp.dropped_full, want.dropped_full));
                if (want.dropped_full)
                    drops_seen++;
            end
        end
    end

    // Receiver stall, with an optional long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            rsp.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned s, input int unsigned r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    task automatic test_directed_edges();
        send_number(CMD_QUERY, 32'd0);
        send_number(CMD_ADD, 32'd0);
        send_number(CMD_ADD, 32'd0);
        send_number(CMD_ADD, 32'hFFFF_FFFF);
        send_number(CMD_ADD, 32'hFFFF_FFFE);
        send_number(CMD_QUERY, 32'hFFFF_FFFF);
        send_number(CMD_ADD, 32'd2);
        send_number(CMD_ADD, 32'd1);
        send_number(CMD_QUERY, 32'd1);
        send_number(CMD_ADD, 32'd5);
        send_number(CMD_ADD, 32'd4);
        send_number(CMD_ADD, 32'd7);
        send_number(CMD_ADD, 32'd6);
        send_number(CMD_QUERY, 32'd3);
        send_number(CMD_ADD, 32'h5555_5555);
        send_number(CMD_ADD, 32'hAAAA_AAAA);
        send_number(CMD_QUERY, 32'hAAAA_AAAA);
        wait_drained();
    endtask

    // Fills the table with isolated numbers, then tests drops and range extensions.
    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH + 4; i++)
            send_number(CMD_ADD, 32'h1000_0000 + 32'(4 * i));
        send_number(CMD_ADD, 32'h1000_0001);
        send_number(CMD_ADD, 32'h1000_0002);
        send_number(CMD_ADD, 32'h0F00_0000);
        send_number(CMD_QUERY, 32'h1000_0002);
        wait_drained();
    endtask

    task automatic test_random_mix(input int unsigned n);
        logic [31:0] base;
        logic [31:0] x;
        isiq_cmd_t op;
        base = $urandom();
        for (int i = 0; i < n; i++)
        begin
            op = ($urandom_range(2) == 0) ? CMD_QUERY : CMD_ADD;
            case ($urandom_range(9))
                0: x = $urandom();
                1: x = $urandom_range(3);
                2: x = 32'hFFFF_FFFF - $urandom_range(3);
                default: x = base + $urandom_range(150);
            endcase
            send_number(op, x);
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 200;
        for (int i = 0; i < 20; i++)
            send_number(CMD_QUERY, $urandom());
        wait_drained();
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.cmd = CMD_ADD;
        req.call_number = '0;
        rsp.ready = 1'b0;
        mismatch_count = 0;
        answers_seen = 0;
        drops_seen = 0;
        used_ranges = 0;
        hold_off_cycles = 0;
        set_idling(0, 0);
        @(posedge rst_n);
        @(posedge clk);

        test_directed_edges();
        test_table_full();
        test_backpressure();
        set_idling(0, 0);
        test_random_mix(450);
        wait_drained();
        set_idling(63, 0);
        test_random_mix(450);
        set_idling(0, 63);
        test_random_mix(450);
        set_idling(6, 6);
        test_random_mix(450);
        wait_drained();
        set_idling(0, 0);
        test_random_mix(150);
        wait_drained();

        $display("covered %0d transactions, %0d of them dropped on a full table",
                 answers_seen, drops_seen);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
